[src/lzd_pkg.sv]
`default_nettype none
package lzd_pkg;

  localparam int CNT_W      = 16;
  localparam int POS_W      = 12;
  localparam int LEN_W      = 7;
  localparam int CMDQ_DEPTH = 4;

  localparam logic [CNT_W-1:0] FREQ_LIMIT = 16'h8000;
  localparam logic [CNT_W-1:0] CNT_TOP    = 16'hffff;
  localparam logic [7:0]       SPACE_BYTE = 8'h20;

  // size of each group of position heads
  localparam logic [4:0] HEAD_GROUP [6] = '{5'd1, 5'd3, 5'd8, 5'd12, 5'd24, 5'd16};

  typedef struct packed {
    logic             is_match;
    logic [POS_W-1:0] data;   // literal byte in low bits, or raw position
    logic [LEN_W-1:0] len;
  } cmd_t;

  // head byte -> {upper position code, total bit length}
  function automatic logic [9:0] head_lookup(input logic [7:0] head);
    logic [8:0] first;
    logic [8:0] size;
    logic [8:0] off;
    logic [5:0] code;
    logic [5:0] res_code;
    logic [3:0] res_len;
    logic       found;
    first    = '0;
    code     = '0;
    res_code = 6'd63;
    res_len  = 4'd8;
    found    = 1'b0;
    for (int g = 0; g < 6; g++) begin
      size = 9'(HEAD_GROUP[g]) << (5 - g);
      if (!found && ({1'b0, head} < first + size)) begin
        off      = {1'b0, head} - first;
        res_code = code + 6'(off >> (5 - g));
        res_len  = 4'(3 + g);
        found    = 1'b1;
      end
      first = first + size;
      code  = code + 6'(HEAD_GROUP[g]);
    end
    return {res_code, res_len};
  endfunction

endpackage
`default_nettype wire

[src/lzd_ram.sv]
`default_nettype none
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/lzd_front.sv]
`default_nettype none
module lzd_front #(
  parameter int MAX_MATCH           = 60,
  parameter int MIN_MATCH_MINUS_ONE = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         restart,
  input  wire logic [31:0]  output_length,
  input  wire logic         push,
  input  wire logic         code_bit,
  output logic              full,
  output logic              q_push,
  output lzd_pkg::cmd_t     q_cmd,
  input  wire logic         q_full
);
  import lzd_pkg::*;

  localparam int SYMS  = 256 - MIN_MATCH_MINUS_ONE + MAX_MATCH;
  localparam int NODES = 2 * SYMS - 1;
  localparam int ROOT  = NODES - 1;
  localparam int NW    = $clog2(NODES + SYMS);
  localparam int CAW   = $clog2(NODES + 1);
  localparam int HAW   = $clog2(NODES);
  localparam int PAW   = $clog2(NODES + SYMS);

  localparam logic [NW-1:0] NODES_V = NW'(NODES);
  localparam logic [NW-1:0] ROOT_V  = NW'(ROOT);
  localparam logic [NW-1:0] SYMS_V  = NW'(SYMS);
  localparam logic [NW-1:0] LAST_V  = NW'(NODES - 1);
  localparam logic [NW-1:0] WALK0_V = NW'(NODES - 3);
  localparam logic [NW-1:0] LIT_V   = NW'(256);

  typedef enum logic [5:0] {
    ST_IN_LEAF, ST_IN_A, ST_IN_B, ST_IN_C, ST_IN_D, ST_IN_END,
    ST_IDLE, ST_SYM, ST_PUSH,
    ST_U0, ST_U1, ST_U2, ST_U3,
    ST_L0, ST_L1, ST_L2, ST_S0, ST_S1,
    ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5,
    ST_P0, ST_P1, ST_FIN0, ST_FIN1,
    ST_RA0, ST_RA1, ST_RB0, ST_RB1, ST_RB2, ST_RC0, ST_RC1,
    ST_RD0, ST_RD1, ST_RD2
  } state_t;

  typedef enum logic [1:0] {PH_SYMBOL, PH_HEAD, PH_EXTRA} phase_t;

  state_t            state;
  phase_t            phase;
  logic [NW-1:0]     walk, sym, c, l, i, j, kk, a, b;
  logic [CNT_W-1:0]  kv, cnt_l, tmp;
  logic [CNT_W:0]    f;
  logic [POS_W-1:0]  pos_bits;
  logic [3:0]        bits_rem;
  logic [LEN_W-1:0]  plen;
  logic [31:0]       sched;

  logic              cnt_we, chd_we, par_we;
  logic [NW-1:0]     cnt_waddr, cnt_raddr, chd_waddr, chd_raddr, par_waddr, par_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_q;
  logic [NW-1:0]     chd_wdata, chd_q, par_wdata, par_q;

  logic [NW-1:0]     idx;
  logic              accept;
  logic              finished;
  logic [3:0]        rem_dec;
  logic [7:0]        head;
  logic [9:0]        head_info;
  logic [5:0]        low6;
  logic [31:0]       room;
  logic [LEN_W-1:0]  eff_len;

  lzd_ram #(.WIDTH(CNT_W), .DEPTH(NODES + 1)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr[CAW-1:0]), .wdata(cnt_wdata),
    .raddr(cnt_raddr[CAW-1:0]), .rdata(cnt_q)
  );
  lzd_ram #(.WIDTH(NW), .DEPTH(NODES)) u_chd (
    .clk(clk), .we(chd_we), .waddr(chd_waddr[HAW-1:0]), .wdata(chd_wdata),
    .raddr(chd_raddr[HAW-1:0]), .rdata(chd_q)
  );
  lzd_ram #(.WIDTH(NW), .DEPTH(NODES + SYMS)) u_par (
    .clk(clk), .we(par_we), .waddr(par_waddr[PAW-1:0]), .wdata(par_wdata),
    .raddr(par_raddr[PAW-1:0]), .rdata(par_q)
  );

  assign full     = (state != ST_IDLE);
  assign accept   = push && !full;
  assign finished = (sched >= output_length);
  assign q_push   = (state == ST_PUSH) && !q_full;

  always_comb begin
    idx = walk + NW'(code_bit);
    if (idx >= NODES_V) begin
      idx = LAST_V;
    end
  end

  assign rem_dec   = (bits_rem == 4'd0) ? 4'd0 : bits_rem - 4'd1;
  assign head      = {pos_bits[6:0], code_bit};
  assign head_info = head_lookup(head);
  assign low6      = {pos_bits[4:0], code_bit};
  assign room      = output_length - sched;
  assign eff_len   = (room < 32'(plen)) ? room[LEN_W-1:0] : plen;

  // memory port control
  always_comb begin
    cnt_we = 1'b0; cnt_waddr = i; cnt_wdata = '0; cnt_raddr = c;
    chd_we = 1'b0; chd_waddr = i; chd_wdata = '0; chd_raddr = idx;
    par_we = 1'b0; par_waddr = i; par_wdata = '0; par_raddr = c;
    case (state)
      ST_IN_LEAF: begin
        cnt_we = 1'b1; cnt_waddr = i; cnt_wdata = 16'd1;
        chd_we = 1'b1; chd_waddr = i; chd_wdata = i + NODES_V;
        par_we = 1'b1; par_waddr = i + NODES_V; par_wdata = i;
      end
      ST_IN_A: cnt_raddr = i;
      ST_IN_B: cnt_raddr = i + 1'b1;
      ST_IN_C: begin
        cnt_we = 1'b1; cnt_waddr = j; cnt_wdata = tmp + cnt_q;
        chd_we = 1'b1; chd_waddr = j; chd_wdata = i;
        par_we = 1'b1; par_waddr = i; par_wdata = j;
      end
      ST_IN_D: begin
        par_we = 1'b1; par_waddr = i + 1'b1; par_wdata = j;
      end
      ST_IN_END: begin
        cnt_we = 1'b1; cnt_waddr = NODES_V; cnt_wdata = CNT_TOP;
        par_we = 1'b1; par_waddr = ROOT_V; par_wdata = '0;
      end
      ST_IDLE: chd_raddr = idx;
      ST_U0:   cnt_raddr = ROOT_V;
      ST_U2:   par_raddr = sym + NODES_V;
      ST_L0:   cnt_raddr = c;
      ST_L1: begin
        cnt_we = 1'b1; cnt_waddr = c; cnt_wdata = cnt_q + 1'b1;
        cnt_raddr = c + 1'b1;
      end
      ST_S0: cnt_raddr = l + 1'b1;
      ST_W0: begin
        cnt_we = 1'b1; cnt_waddr = c; cnt_wdata = cnt_l;
        chd_raddr = c;
      end
      ST_W1: begin
        cnt_we = 1'b1; cnt_waddr = l; cnt_wdata = kv;
        chd_raddr = l;
      end
      ST_W2: begin
        chd_we = 1'b1; chd_waddr = l; chd_wdata = a;
        par_we = 1'b1; par_waddr = a; par_wdata = l;
      end
      ST_W3: begin
        chd_we = 1'b1; chd_waddr = c; chd_wdata = b;
        par_we = (a < NODES_V); par_waddr = a + 1'b1; par_wdata = l;
      end
      ST_W4: begin
        par_we = 1'b1; par_waddr = b; par_wdata = c;
      end
      ST_W5: begin
        par_we = (b < NODES_V); par_waddr = b + 1'b1; par_wdata = c;
      end
      ST_P0:   par_raddr = c;
      ST_FIN0: chd_raddr = ROOT_V;
      ST_RA0: begin
        cnt_raddr = i; chd_raddr = i;
      end
      ST_RA1: begin
        if (chd_q >= NODES_V) begin
          cnt_we = 1'b1; cnt_waddr = j;
          cnt_wdata = CNT_W'(({1'b0, cnt_q} + 17'd1) >> 1);
          chd_we = 1'b1; chd_waddr = j; chd_wdata = chd_q;
        end
      end
      ST_RB0: cnt_raddr = i;
      ST_RB1: cnt_raddr = i + 1'b1;
      ST_RC0: begin
        if (kk == '0) begin
          cnt_we = 1'b1; cnt_waddr = '0; cnt_wdata = f[CNT_W-1:0];
          chd_we = 1'b1; chd_waddr = '0; chd_wdata = i;
        end else begin
          cnt_raddr = kk - 1'b1; chd_raddr = kk - 1'b1;
        end
      end
      ST_RC1: begin
        cnt_we = 1'b1; cnt_waddr = kk;
        chd_we = 1'b1; chd_waddr = kk;
        if (f < {1'b0, cnt_q}) begin
          cnt_wdata = cnt_q; chd_wdata = chd_q;
        end else begin
          cnt_wdata = f[CNT_W-1:0]; chd_wdata = i;
        end
      end
      ST_RD0: chd_raddr = i;
      ST_RD1: begin
        par_we = 1'b1; par_waddr = chd_q; par_wdata = i;
      end
      ST_RD2: begin
        par_we = 1'b1; par_waddr = a + 1'b1; par_wdata = i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state    <= ST_IN_LEAF;
      phase    <= PH_SYMBOL;
      i        <= '0;
      j        <= '0;
      walk     <= WALK0_V;
      pos_bits <= '0;
      bits_rem <= '0;
      plen     <= '0;
      sched    <= '0;
    end else begin
      case (state)
        ST_IN_LEAF: begin
          if (i == SYMS_V - 1'b1) begin
            i     <= '0;
            j     <= SYMS_V;
            state <= ST_IN_A;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_IN_A: state <= ST_IN_B;
        ST_IN_B: begin
          tmp   <= cnt_q;
          state <= ST_IN_C;
        end
        ST_IN_C: state <= ST_IN_D;
        ST_IN_D: begin
          i <= i + NW'(2);
          if (j == ROOT_V) begin
            state <= ST_IN_END;
          end else begin
            j     <= j + 1'b1;
            state <= ST_IN_A;
          end
        end
        ST_IN_END: begin
          walk  <= WALK0_V;
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept && !finished) begin
            case (phase)
              PH_SYMBOL: state <= ST_SYM;
              PH_HEAD: begin
                if (rem_dec == 4'd0) begin
                  pos_bits <= {head_info[9:4], head[5:0]};
                  bits_rem <= head_info[3:0] - 4'd2;
                  phase    <= PH_EXTRA;
                end else begin
                  pos_bits <= {4'd0, head};
                  bits_rem <= rem_dec;
                end
              end
              PH_EXTRA: begin
                bits_rem <= rem_dec;
                pos_bits <= {pos_bits[11:6], low6};
                if (rem_dec == 4'd0) begin
                  q_cmd.is_match <= 1'b1;
                  q_cmd.data     <= {pos_bits[11:6], low6};
                  q_cmd.len      <= eff_len;
                  sched          <= sched + 32'(eff_len);
                  plen           <= '0;
                  phase          <= PH_SYMBOL;
                  state          <= ST_PUSH;
                end
              end
              default: phase <= PH_SYMBOL;
            endcase
          end
        end
        ST_SYM: begin
          if (chd_q < NODES_V) begin
            walk  <= chd_q;
            state <= ST_IDLE;
          end else begin
            sym   <= chd_q - NODES_V;
            state <= ST_U0;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        ST_U0: state <= ST_U1;
        ST_U1: begin
          if (cnt_q == FREQ_LIMIT) begin
            i     <= '0;
            j     <= '0;
            state <= ST_RA0;
          end else begin
            state <= ST_U2;
          end
        end
        ST_U2: state <= ST_U3;
        ST_U3: begin
          c     <= par_q;
          state <= ST_L0;
        end
        ST_L0: state <= ST_L1;
        ST_L1: begin
          kv    <= cnt_q + 1'b1;
          state <= ST_L2;
        end
        ST_L2: begin
          if (kv > cnt_q) begin
            l     <= c + 1'b1;
            cnt_l <= cnt_q;
            state <= ST_S0;
          end else begin
            state <= ST_P0;
          end
        end
        ST_S0: state <= (l + 1'b1 < NODES_V) ? ST_S1 : ST_W0;
        ST_S1: begin
          if (kv > cnt_q) begin
            l     <= l + 1'b1;
            cnt_l <= cnt_q;
            state <= ST_S0;
          end else begin
            state <= ST_W0;
          end
        end
        ST_W0: state <= ST_W1;
        ST_W1: begin
          a     <= chd_q;
          state <= ST_W2;
        end
        ST_W2: begin
          b     <= chd_q;
          state <= ST_W3;
        end
        ST_W3: state <= ST_W4;
        ST_W4: state <= ST_W5;
        ST_W5: begin
          c     <= l;
          state <= ST_P0;
        end
        ST_P0: state <= ST_P1;
        ST_P1: begin
          if (par_q == '0) begin
            state <= ST_FIN0;
          end else begin
            c     <= par_q;
            state <= ST_L0;
          end
        end
        ST_FIN0: state <= ST_FIN1;
        ST_FIN1: begin
          walk <= chd_q;
          if (sym < LIT_V) begin
            q_cmd.is_match <= 1'b0;
            q_cmd.data     <= {4'd0, sym[7:0]};
            q_cmd.len      <= LEN_W'(1);
            sched          <= sched + 32'd1;
            state          <= ST_PUSH;
          end else begin
            plen     <= LEN_W'(sym - NW'(255) + NW'(MIN_MATCH_MINUS_ONE));
            pos_bits <= '0;
            bits_rem <= 4'd8;
            phase    <= PH_HEAD;
            state    <= ST_IDLE;
          end
        end
        // rebuild: gather halved leaves at the bottom
        ST_RA0: state <= ST_RA1;
        ST_RA1: begin
          if (chd_q >= NODES_V) begin
            j <= j + 1'b1;
          end
          if (i == LAST_V) begin
            i     <= '0;
            j     <= SYMS_V;
            state <= ST_RB0;
          end else begin
            i     <= i + 1'b1;
            state <= ST_RA0;
          end
        end
        // rebuild: pair nodes and insert the sum in sorted place
        ST_RB0: state <= ST_RB1;
        ST_RB1: begin
          tmp   <= cnt_q;
          state <= ST_RB2;
        end
        ST_RB2: begin
          f     <= {1'b0, tmp} + {1'b0, cnt_q};
          kk    <= j;
          state <= ST_RC0;
        end
        ST_RC0: begin
          if (kk == '0) begin
            i <= i + NW'(2);
            if (j == LAST_V) begin
              i     <= '0;
              state <= ST_RD0;
            end else begin
              j     <= j + 1'b1;
              state <= ST_RB0;
            end
          end else begin
            state <= ST_RC1;
          end
        end
        ST_RC1: begin
          if (f < {1'b0, cnt_q}) begin
            kk    <= kk - 1'b1;
            state <= ST_RC0;
          end else begin
            i <= i + NW'(2);
            if (j == LAST_V) begin
              i     <= '0;
              state <= ST_RD0;
            end else begin
              j     <= j + 1'b1;
              state <= ST_RB0;
            end
          end
        end
        // rebuild: relink parents
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          a <= chd_q;
          if (chd_q < NODES_V) begin
            state <= ST_RD2;
          end else if (i == LAST_V) begin
            state <= ST_U2;
          end else begin
            i     <= i + 1'b1;
            state <= ST_RD0;
          end
        end
        ST_RD2: begin
          if (i == LAST_V) begin
            state <= ST_U2;
          end else begin
            i     <= i + 1'b1;
            state <= ST_RD0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/lzd_cmdq.sv]
`default_nettype none
module lzd_cmdq (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     restart,
  input  wire logic     push,
  input  lzd_pkg::cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output lzd_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import lzd_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full    = (count == (PW+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

[src/lzd_back.sv]
`default_nettype none
module lzd_back #(
  parameter int WINDOW_SIZE = 1024,
  parameter int MAX_MATCH   = 60
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        restart,
  input  wire logic [31:0] output_length,
  input  wire logic        q_empty,
  input  lzd_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             stream_done
);
  import lzd_pkg::*;

  localparam int WAW = $clog2(WINDOW_SIZE);
  localparam int TW  = WAW + 2;

  localparam logic [WAW-1:0]  WLAST_V = WAW'(WINDOW_SIZE - 1);
  localparam logic [WAW-1:0]  WI0_V   = WAW'(WINDOW_SIZE - MAX_MATCH);
  localparam logic [POS_W:0]  WPOS_V  = (POS_W+1)'(WINDOW_SIZE);
  localparam logic [TW-1:0]   WT_V    = TW'(WINDOW_SIZE);

  typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_MOD, ST_RD, ST_WR} state_t;

  state_t           state;
  logic [WAW-1:0]   wi, src;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] rem;
  logic [31:0]      produced;
  logic             is_lit;
  logic [7:0]       lit;
  logic             ovalid;

  logic             win_we;
  logic [WAW-1:0]   win_waddr;
  logic [7:0]       win_wdata, win_q, byte_now;
  logic             emit;
  logic [TW-1:0]    back_dist;

  lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_win (
    .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
    .raddr(src), .rdata(win_q)
  );

  assign empty    = !ovalid;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign byte_now = is_lit ? lit : win_q;
  assign emit     = (state == ST_WR) && (!ovalid || pop);
  assign back_dist = TW'(wi) + WT_V - TW'(pos) - TW'(1);

  always_comb begin
    win_we    = 1'b0;
    win_waddr = wi;
    win_wdata = byte_now;
    if (state == ST_CLR) begin
      win_we    = 1'b1;
      win_waddr = src;
      win_wdata = (src < WI0_V) ? SPACE_BYTE : 8'd0;
    end else if (emit) begin
      win_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state    <= ST_CLR;
      src      <= '0;
      wi       <= WI0_V;
      produced <= '0;
      ovalid   <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          if (src == WLAST_V) begin
            state <= ST_IDLE;
          end else begin
            src <= src + 1'b1;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            is_lit <= !q_cmd.is_match;
            lit    <= q_cmd.data[7:0];
            pos    <= q_cmd.data;
            rem    <= q_cmd.len;
            state  <= q_cmd.is_match ? ST_MOD : ST_WR;
          end
        end
        ST_MOD: begin
          if ({1'b0, pos} >= WPOS_V) begin
            pos <= pos - WPOS_V[POS_W-1:0];
          end else begin
            src   <= (back_dist >= WT_V) ? WAW'(back_dist - WT_V) : WAW'(back_dist);
            state <= ST_RD;
          end
        end
        ST_RD: state <= ST_WR;
        ST_WR: begin
          if (emit) begin
            out_byte    <= byte_now;
            run_last    <= (rem == LEN_W'(1));
            stream_done <= (produced + 32'd1 == output_length);
            produced    <= produced + 32'd1;
            wi          <= (wi == WLAST_V) ? '0 : wi + 1'b1;
            src         <= (src == WLAST_V) ? '0 : src + 1'b1;
            rem         <= rem - 1'b1;
            state       <= (rem == LEN_W'(1)) ? ST_IDLE : ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/lzhuf_decompressor_core.sv]
// LZHUF stream decoder, one compressed bit per pushed item.
// A tree-walk bit passes through the idle and symbol states, and a position bit is taken in idle;
// a leaf bit adds the tree update (each ancestor is incremented, with a scan and swap where the
// order breaks, and a halving rebuild when the root count reaches the limit); a match emits its
// bytes through the read and write states. Throughput is set by the count, link and window
// memories, each with one read and one write port. Reset or a length write reloads the tree and
// refills the window; full stays high until the tree is loaded.
`default_nettype none
module lzhuf_decompressor_core #(
  parameter int WINDOW_SIZE         = 1024,
  parameter int MAX_MATCH           = 60,
  parameter int MIN_MATCH_MINUS_ONE = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // bit input
  input  wire logic        push,
  output logic             full,
  input  wire logic        code_bit,
  // decoded bytes
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             stream_done,
  // output length register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import lzd_pkg::*;

  logic [31:0] output_length;
  logic        restart;
  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        push_cmd, pop_cmd;

  // the length register is always writable; a write restarts the whole decoder
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (restart) begin
      output_length <= cfg_data;
    end
  end

  // front: walk and update the Huffman tree, decode position, issue literal/match items
  lzd_front #(
    .MAX_MATCH(MAX_MATCH), .MIN_MATCH_MINUS_ONE(MIN_MATCH_MINUS_ONE)
  ) u_front (
    .clk(clk), .rst(rst), .restart(restart), .output_length(output_length),
    .push(push), .code_bit(code_bit), .full(full),
    .q_push(q_push), .q_cmd(push_cmd), .q_full(q_full)
  );

  // short queue so tree work and window copies overlap
  lzd_cmdq u_cmdq (
    .clk(clk), .rst(rst), .restart(restart),
    .push(q_push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .pop_cmd(pop_cmd), .empty(q_empty)
  );

  // back: run the window copies and hold the output register
  lzd_back #(.WINDOW_SIZE(WINDOW_SIZE), .MAX_MATCH(MAX_MATCH)) u_back (
    .clk(clk), .rst(rst), .restart(restart), .output_length(output_length),
    .q_empty(q_empty), .q_cmd(pop_cmd), .q_pop(q_pop),
    .empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
    .stream_done(stream_done)
  );
endmodule
`default_nettype wire
